// ===== rtl/hse_pkg.sv =====
// Shared types and constants for the heap sort engine.
// Used by the channel interfaces, the sort core and the top level.
package hse_pkg;

  localparam int HSE_MAX_KEYS = 64;
  localparam int HSE_KEY_W    = 32;

  typedef logic signed [HSE_KEY_W-1:0] key_t;

  // Requests from the top level to the sort core.
  typedef struct packed {
    logic start;
    logic wr_en;
    logic rd_en;
  } hse_req_t;

endpackage

// ===== rtl/hse_if.sv =====
// Valid/ready channel interfaces for the heap sort engine.
// Depends on hse_pkg for the key type.
interface hse_in_if import hse_pkg::*; ();
  logic valid;
  logic ready;
  key_t key;
  logic last;

  modport source (output valid, output key, output last, input ready);
  modport sink   (input valid, input key, input last, output ready);
endinterface

interface hse_out_if import hse_pkg::*; ();
  logic valid;
  logic ready;
  key_t sorted_key;
  logic last_res;
  logic overflow;

  modport source (output valid, output sorted_key, output last_res, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_key, input last_res, input overflow,
                  output ready);
endinterface

// ===== rtl/heap_sort_engine.sv =====
// Heap sort engine top level: key loading, batch control and result register.
// Depends on hse_pkg, hse_if (channel interfaces) and hse_sorter.
//
//   channel | dir | payload                            | accepted when
//   in_ch   | in  | key, last                          | valid && ready
//   out_ch  | out | sorted_key, last_res, overflow     | valid && ready
//
// Keys load into the key memory at one word per cycle while loading. The word
// that carries last starts an in-place heapsort; each sift level compares both
// children, read at once from the dual-read memory. Results then leave at one
// word per cycle, while out_ch is ready, from a registered output stage. Reset
// is synchronous and active low; it clears the key count, the drop flag, the
// state and the output valid, and the memory needs no clearing pass. A stalled
// output holds its word; input is taken only while loading, but the last result
// may still wait on out_ch.
module heap_sort_engine import hse_pkg::*; #(
  parameter int MAX_KEYS = HSE_MAX_KEYS
) (
  input  logic        clk,
  input  logic        rst_n,
  hse_in_if.sink      in_ch,
  hse_out_if.source   out_ch
);

  localparam int IDX_W = $clog2(MAX_KEYS);
  localparam int CNT_W = $clog2(MAX_KEYS + 1);

  typedef enum logic [1:0] {ST_LOAD, ST_SORT, ST_EMIT} state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              drop_r, drop_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic              out_valid_r, out_valid_nxt;
  key_t              out_key_r, out_key_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  hse_req_t          req;
  logic [IDX_W-1:0]  rd_addr;
  logic              sort_done;
  key_t              rd_data;

  logic              in_take;
  logic              slot_free;
  logic              emit_load;
  logic              emit_last;

  // Input is taken only while loading a batch.
  assign in_ch.ready = (state_r == ST_LOAD);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign emit_last   = (CNT_W'(k_r) + CNT_W'(1)) == cnt_r;
  assign emit_load   = (state_r == ST_EMIT) && slot_free;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    drop_nxt      = drop_r;
    k_nxt         = k_r;
    out_key_nxt   = out_key_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    req           = '0;
    rd_addr       = k_r;

    unique case (state_r)
      ST_LOAD: begin
        if (in_take) begin
          if (cnt_r < CNT_W'(MAX_KEYS)) begin
            req.wr_en = 1'b1;
            cnt_nxt   = cnt_r + CNT_W'(1);
          end else begin
            // Store is full: the word is lost but the batch is marked.
            drop_nxt = 1'b1;
          end
          if (in_ch.last) begin
            req.start = 1'b1;
            state_nxt = ST_SORT;
          end
        end
      end
      ST_SORT: begin
        if (sort_done) begin
          // Fetch the smallest key; it is ready for the first emit cycle.
          req.rd_en = 1'b1;
          rd_addr   = '0;
          k_nxt     = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_key_nxt   = rd_data;
          out_last_nxt  = emit_last;
          out_ovf_nxt   = drop_r;
          if (emit_last) begin
            cnt_nxt   = '0;
            drop_nxt  = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            k_nxt     = k_r + IDX_W'(1);
            req.rd_en = 1'b1;
            rd_addr   = k_r + IDX_W'(1);
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    k_r        <= k_nxt;
    out_key_r  <= out_key_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  hse_sorter #(
    .MAX_KEYS (MAX_KEYS)
  ) u_sorter (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .wr_addr (cnt_r[IDX_W-1:0]),
    .wr_data (in_ch.key),
    .rd_addr (rd_addr),
    .n       (cnt_nxt),
    .done    (sort_done),
    .rd_data (rd_data)
  );

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sorted_key = out_key_r;
  assign out_ch.last_res   = out_last_r;
  assign out_ch.overflow   = out_ovf_r;

`ifndef SYNTHESIS
  // The key count never passes the store capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_KEYS))
    else $error("key count beyond capacity");

  // The sort core finishes only while the top level waits for it.
  a_done_in_sort: assert property (@(posedge clk) disable iff (!rst_n)
    sort_done |-> (state_r == ST_SORT))
    else $error("sort finished outside the sort phase");

  // Emitting the final word of a batch clears the batch state.
  a_batch_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_load && emit_last) |=> (cnt_r == '0 && !drop_r && state_r == ST_LOAD))
    else $error("batch state not cleared after the final word");

  // A word is loaded into the output stage only when a batch holds keys.
  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    emit_load |-> (cnt_r != '0))
    else $error("emitting from an empty batch");
`endif

endmodule

// ===== rtl/hse_sorter.sv =====
// Key memory and in-place heapsort sequencer of the heap sort engine.
// Depends on hse_pkg. The memory has one write port and two registered read ports.
module hse_sorter import hse_pkg::*; #(
  parameter int MAX_KEYS = HSE_MAX_KEYS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  hse_req_t                         req,
  input  logic [$clog2(MAX_KEYS)-1:0]      wr_addr,
  input  key_t                             wr_data,
  input  logic [$clog2(MAX_KEYS)-1:0]      rd_addr,
  input  logic [$clog2(MAX_KEYS+1)-1:0]    n,
  output logic                             done,
  output key_t                             rd_data
);

  localparam int IDX_W = $clog2(MAX_KEYS);
  localparam int CNT_W = $clog2(MAX_KEYS + 1);
  localparam int CH_W  = IDX_W + 2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SIFT_RD, ST_SIFT_HELD, ST_SIFT_CMP, ST_SIFT_PUT,
    ST_SWAP_RD, ST_SWAP_WR, ST_FIX0
  } state_t;

  key_t mem [MAX_KEYS];
  key_t rda_r, rdb_r;

  state_t            state_r, state_nxt;
  logic              extract_r, extract_nxt;
  logic [IDX_W-1:0]  root_r, root_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  key_t              held_r, held_nxt;
  logic              done_r, done_nxt;

  logic              we, re;
  logic [IDX_W-1:0]  waddr, ra_addr, rb_addr;
  key_t              wdata;

  logic [CH_W-1:0]   child_c, child_p1, tail_x, gchild;
  logic              pick_right, go_down;
  logic [IDX_W-1:0]  pick_idx;
  key_t              pick_val;
  logic              sift_done;
  logic [CNT_W-1:0]  half_n;

  assign child_c    = {1'b0, root_r, 1'b1};
  assign child_p1   = child_c + CH_W'(1);
  assign tail_x     = {2'b00, tail_r};
  assign pick_right = (child_c < tail_x) && (rda_r < rdb_r);
  assign pick_idx   = pick_right ? child_p1[IDX_W-1:0] : child_c[IDX_W-1:0];
  assign pick_val   = pick_right ? rdb_r : rda_r;
  assign go_down    = held_r < pick_val;
  assign gchild     = {1'b0, pick_idx, 1'b1};
  assign half_n     = n >> 1;

  always_comb begin
    state_nxt   = state_r;
    extract_nxt = extract_r;
    root_nxt    = root_r;
    tail_nxt    = tail_r;
    idx_nxt     = idx_r;
    held_nxt    = held_r;
    done_nxt    = 1'b0;
    we          = 1'b0;
    waddr       = root_r;
    wdata       = held_r;
    re          = 1'b0;
    ra_addr     = root_r;
    rb_addr     = root_r;
    sift_done   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        we      = req.wr_en;
        waddr   = wr_addr;
        wdata   = wr_data;
        re      = req.rd_en;
        ra_addr = rd_addr;
        if (req.start) begin
          if (n < CNT_W'(2)) begin
            done_nxt = 1'b1;
          end else begin
            extract_nxt = 1'b0;
            tail_nxt    = IDX_W'(n - CNT_W'(1));
            idx_nxt     = IDX_W'(half_n - CNT_W'(1));
            root_nxt    = IDX_W'(half_n - CNT_W'(1));
            state_nxt   = ST_SIFT_RD;
          end
        end
      end
      ST_SIFT_RD: begin
        re        = 1'b1;
        ra_addr   = root_r;
        state_nxt = ST_SIFT_HELD;
      end
      ST_SIFT_HELD: begin
        held_nxt = rda_r;
        if (child_c > tail_x) begin
          // A leaf needs no move.
          sift_done = 1'b1;
        end else begin
          re        = 1'b1;
          ra_addr   = child_c[IDX_W-1:0];
          rb_addr   = child_p1[IDX_W-1:0];
          state_nxt = ST_SIFT_CMP;
        end
      end
      ST_SIFT_CMP: begin
        we = 1'b1;
        waddr = root_r;
        if (go_down) begin
          // Pull the larger child up and follow the hole downward.
          wdata    = pick_val;
          root_nxt = pick_idx;
          if (gchild > tail_x) begin
            state_nxt = ST_SIFT_PUT;
          end else begin
            re      = 1'b1;
            ra_addr = gchild[IDX_W-1:0];
            rb_addr = IDX_W'(gchild + CH_W'(1));
          end
        end else begin
          wdata     = held_r;
          sift_done = 1'b1;
        end
      end
      ST_SIFT_PUT: begin
        we        = 1'b1;
        waddr     = root_r;
        wdata     = held_r;
        sift_done = 1'b1;
      end
      ST_SWAP_RD: begin
        re        = 1'b1;
        ra_addr   = '0;
        rb_addr   = idx_r;
        state_nxt = ST_SWAP_WR;
      end
      ST_SWAP_WR: begin
        // The old root goes to the tail; the old tail becomes the held key.
        we       = 1'b1;
        waddr    = idx_r;
        wdata    = rda_r;
        held_nxt = rdb_r;
        tail_nxt = idx_r - IDX_W'(1);
        root_nxt = '0;
        if (idx_r == IDX_W'(1)) begin
          state_nxt = ST_FIX0;
        end else begin
          re        = 1'b1;
          ra_addr   = IDX_W'(1);
          rb_addr   = IDX_W'(2);
          state_nxt = ST_SIFT_CMP;
        end
      end
      ST_FIX0: begin
        we        = 1'b1;
        waddr     = '0;
        wdata     = held_r;
        done_nxt  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (sift_done) begin
      if (!extract_r) begin
        if (idx_r == '0) begin
          extract_nxt = 1'b1;
          idx_nxt     = tail_r;
          state_nxt   = ST_SWAP_RD;
        end else begin
          idx_nxt   = idx_r - IDX_W'(1);
          root_nxt  = idx_r - IDX_W'(1);
          state_nxt = ST_SIFT_RD;
        end
      end else begin
        idx_nxt   = idx_r - IDX_W'(1);
        state_nxt = ST_SWAP_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      extract_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      extract_r <= extract_nxt;
      done_r    <= done_nxt;
    end
    root_r <= root_nxt;
    tail_r <= tail_nxt;
    idx_r  <= idx_nxt;
    held_r <= held_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rda_r <= mem[ra_addr];
      rdb_r <= mem[rb_addr];
    end
  end

  assign done    = done_r;
  assign rd_data = rda_r;

endmodule
